// ===== sv/torus_x_wrapping_union_find_unit_assert.svh =====
// Assertion macros used by the checker of the wrapping union-find unit.
`ifndef TORUS_X_WRAPPING_UNION_FIND_UNIT_ASSERT_SVH
`define TORUS_X_WRAPPING_UNION_FIND_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante; expects clk and arst_n in scope.
`define TXWUF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("txwuf check failed in the same cycle");

// Check cons in the cycle after ante.
`define TXWUF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("txwuf check failed one cycle later");

`endif

// ===== sv/txwuf_pkg.sv =====
// Package: grid size, index and offset widths for the wrapping union-find unit.
`timescale 1ns / 1ps
package txwuf_pkg;
	localparam int SIDE  = 5;
	localparam int CELLS = SIDE * SIDE;
	localparam int IDX_W = $clog2(CELLS);
	localparam int RC_W  = $clog2(SIDE);
	localparam int OFF_W = 7;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [RC_W-1:0]         rc_t;
	typedef logic signed [OFF_W-1:0] off_t;
	typedef logic [CELLS-1:0]        word_t;
endpackage

// ===== sv/txwuf_occ_if.sv =====
// Interface: valid/ready channel carrying one occupancy word.
`timescale 1ns / 1ps
interface txwuf_occ_if import txwuf_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t occupancy_word;

	modport source (output valid, output occupancy_word, input ready);
	modport sink (input valid, input occupancy_word, output ready);
endinterface

// ===== sv/txwuf_res_if.sv =====
// Interface: valid/ready channel carrying the wrapping answer.
`timescale 1ns / 1ps
interface txwuf_res_if import txwuf_pkg::*; ();
	logic valid;
	logic ready;
	logic wraps_horizontally;

	modport source (output valid, output wraps_horizontally, input ready);
	modport sink (input valid, input wraps_horizontally, output ready);
endinterface

// ===== sv/torus_x_wrapping_union_find_unit.sv =====
// Top level: horizontal wrapping test on a periodic grid by union-find with offsets.
//
// occ carries one occupancy word per item (bit row*SIDE+column, 1 = occupied);
// result carries one word per item, wraps_horizontally = 1 when an occupied
// cluster winds around the torus horizontally. Both are valid/ready channels.
// The unit takes a word only when idle, then scans the 2*CELLS right/down edge
// slots in row-major order with one sequencer and a link store that has one
// read port and one write port and is cleared as a whole when a word is taken.
// For every live edge (both cells occupied) it runs a find on each of the two
// cells, walking the store one link per cycle and then relinking every node on
// the path straight to its root (compression keeps the paths short), and then
// joins the two roots. A new word is accepted only once the last one is done.
// Processing stops early at the first loop with a nonzero horizontal offset.
// The answer sits in an output register, so a new word is accepted while a
// stalled answer waits; a finished answer waits in place until that register
// frees up. Reset clears the sequencer and the output register; the link
// store is rebuilt at the start of every word.
`timescale 1ns / 1ps
module torus_x_wrapping_union_find_unit import txwuf_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	txwuf_occ_if.sink   occ,
	txwuf_res_if.source result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EDGE = 3'd1;
	localparam logic [2:0] ST_WALK = 3'd2;
	localparam logic [2:0] ST_COMP = 3'd3;
	localparam logic [2:0] ST_JOIN = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	word_t      word_q;
	rc_t        r_q, c_q;
	idx_t       i_q;
	logic       down_q;    // 0: right edge slot, 1: down edge slot
	logic       fsel_q;    // 0: find on the scanned cell, 1: find on its neighbor
	idx_t       node_q;    // start node of the current find
	idx_t       cur_q;
	idx_t       root_q;
	idx_t       ra_q;
	off_t       sum_q;
	off_t       oa_q, ob_q;
	logic       wrap_q;
	logic       out_valid_q;
	logic       out_bit_q;

	// link store: parent and horizontal offset to parent per cell
	idx_t par_q [CELLS];
	off_t off_q [CELLS];

	idx_t rd_par;
	off_t rd_off;
	idx_t nb_idx;
	logic c_last, r_last;
	logic edge_live;
	logic last_slot;
	idx_t nxt_i;
	rc_t  nxt_r, nxt_c;
	off_t addend;
	off_t add_c;
	logic signed [OFF_W:0] oa_x, ob_x, dx_x, diff_c;
	logic accept;
	logic init;
	logic we_c;
	idx_t waddr_c, wpar_c;
	off_t woff_c;

	assign occ.ready                 = (state_q == ST_IDLE);
	assign accept                    = occ.valid && occ.ready;
	assign result.valid              = out_valid_q;
	assign result.wraps_horizontally = out_bit_q;

	assign rd_par = par_q[cur_q];
	assign rd_off = off_q[cur_q];

	// neighbor of the scanned cell, wrapping at the grid edges
	assign c_last = (c_q == rc_t'(SIDE - 1));
	assign r_last = (r_q == rc_t'(SIDE - 1));
	always_comb begin
		if (!down_q) begin
			nb_idx = c_last ? (i_q - idx_t'(SIDE - 1)) : (i_q + idx_t'(1));
		end else begin
			nb_idx = r_last ? idx_t'(c_q) : (i_q + idx_t'(SIDE));
		end
	end
	assign edge_live = word_q[i_q] && word_q[nb_idx];
	assign last_slot = down_q && (i_q == idx_t'(CELLS - 1));

	// step to the next edge slot: right then down, then the next cell
	always_comb begin
		nxt_i = i_q;
		nxt_r = r_q;
		nxt_c = c_q;
		if (down_q) begin
			nxt_i = i_q + idx_t'(1);
			nxt_c = c_last ? '0 : (c_q + rc_t'(1));
			nxt_r = c_last ? (r_q + rc_t'(1)) : r_q;
		end
	end

	// shared offset adder: accumulate on the walk, peel off on compression
	assign addend = (state_q == ST_COMP) ? -rd_off : rd_off;
	assign add_c  = sum_q + addend;

	// loop offset oa + dx - ob, one bit wider than the stored offsets
	assign oa_x   = {oa_q[OFF_W-1], oa_q};
	assign ob_x   = {ob_q[OFF_W-1], ob_q};
	assign dx_x   = {{OFF_W{1'b0}}, !down_q};
	assign diff_c = oa_x + dx_x - ob_x;

	// single write port of the store
	assign init = accept;
	always_comb begin
		we_c    = 1'b0;
		waddr_c = root_q;
		wpar_c  = ra_q;
		woff_c  = diff_c[OFF_W-1:0];
		if (state_q == ST_COMP) begin
			we_c    = (cur_q != root_q);
			waddr_c = cur_q;
			wpar_c  = root_q;
			woff_c  = sum_q;
		end else if (state_q == ST_JOIN) begin
			we_c = (ra_q != root_q);
		end
	end

	always_ff @(posedge clk) begin
		if (init) begin
			for (int k = 0; k < CELLS; k++) begin
				par_q[k] <= idx_t'(k);
				off_q[k] <= '0;
			end
		end else if (we_c) begin
			par_q[waddr_c] <= wpar_c;
			off_q[waddr_c] <= woff_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			word_q      <= '0;
			r_q         <= '0;
			c_q         <= '0;
			i_q         <= '0;
			down_q      <= 1'b0;
			fsel_q      <= 1'b0;
			node_q      <= '0;
			cur_q       <= '0;
			root_q      <= '0;
			ra_q        <= '0;
			sum_q       <= '0;
			oa_q        <= '0;
			ob_q        <= '0;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			// load a finished answer, or drop the one the receiver takes
			if ((state_q == ST_DONE) && (!out_valid_q || result.ready)) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						word_q  <= occ.occupancy_word;
						r_q     <= '0;
						c_q     <= '0;
						i_q     <= '0;
						down_q  <= 1'b0;
						wrap_q  <= 1'b0;
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					if (edge_live) begin
						cur_q   <= i_q;
						node_q  <= i_q;
						sum_q   <= '0;
						fsel_q  <= 1'b0;
						state_q <= ST_WALK;
					end else if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						down_q <= !down_q;
						i_q    <= nxt_i;
						r_q    <= nxt_r;
						c_q    <= nxt_c;
					end
				end
				ST_WALK: begin
					if (rd_par == cur_q) begin
						// root reached: sum_q is the offset from the start node
						root_q <= cur_q;
						cur_q  <= node_q;
						if (fsel_q) begin
							ob_q <= sum_q;
						end else begin
							oa_q <= sum_q;
						end
						state_q <= ST_COMP;
					end else begin
						sum_q <= add_c;
						cur_q <= rd_par;
					end
				end
				ST_COMP: begin
					if (cur_q == root_q) begin
						if (!fsel_q) begin
							ra_q    <= root_q;
							fsel_q  <= 1'b1;
							cur_q   <= nb_idx;
							node_q  <= nb_idx;
							sum_q   <= '0;
							state_q <= ST_WALK;
						end else begin
							state_q <= ST_JOIN;
						end
					end else begin
						// relink this node to the root, advance along the old path
						sum_q <= add_c;
						cur_q <= rd_par;
					end
				end
				ST_JOIN: begin
					if ((ra_q == root_q) && (diff_c != '0)) begin
						wrap_q  <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_slot) begin
						state_q <= ST_DONE;
					end else begin
						down_q  <= !down_q;
						i_q     <= nxt_i;
						r_q     <= nxt_r;
						c_q     <= nxt_c;
						state_q <= ST_EDGE;
					end
				end
				ST_DONE: begin
					// hold the answer until the output register is free
					if (!out_valid_q || result.ready) begin
						out_bit_q <= wrap_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/txwuf_checker.sv =====
// Checker on the ports of the wrapping union-find unit, with its bind statement.
`timescale 1ns / 1ps
`include "torus_x_wrapping_union_find_unit_assert.svh"
module txwuf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_bit
);

	logic [1:0] pend_q;
	logic       acc;
	logic       del;

	assign acc = in_valid && in_ready;
	assign del = out_valid && out_ready;

	// words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, acc} - {1'b0, del};
		end
	end

	`TXWUF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bit))
	`TXWUF_ASSERT_NEXT(a_busy_after_accept, acc, !in_ready)
	`TXWUF_ASSERT_SAME(a_no_spurious_answer, out_valid, pend_q != 2'd0)
	`TXWUF_ASSERT_SAME(a_one_word_in_flight, acc, pend_q != 2'd2)

endmodule

bind torus_x_wrapping_union_find_unit txwuf_checker u_txwuf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (occ.valid),
	.in_ready  (occ.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_bit   (result.wraps_horizontally)
);
